[rtl/core/erld_pkg.sv]
// Shared types and constants for the extent run-list decoder.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package erld_pkg;

  localparam int unsigned CLUSTER_W = 64;
  localparam int unsigned RUNS_W    = 16;

  localparam logic [RUNS_W-1:0] MAX_RUNS_RESET = 16'hFFFF;

  // Kind of a result item.
  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // Why a list ended.
  typedef enum logic [1:0] {
    REASON_TERMINATOR = 2'd0,
    REASON_ZERO_LEN   = 2'd1,
    REASON_RUN_LIMIT  = 2'd2,
    REASON_WIDE_COUNT = 2'd3
  } reason_t;

  typedef struct packed {
    logic                 result_kind;
    logic [CLUSTER_W-1:0] run_lcn;
    logic [CLUSTER_W-1:0] run_length;
    logic                 sparse_run;
    logic [RUNS_W-1:0]    runs_so_far;
    reason_t              end_reason;
    logic                 last;
  } res_t;

endpackage

[rtl/core/extent_run_list_decoder.sv]
// Top level of the extent run-list decoder: configuration register, byte
// decoder and result buffer. Depends on erld_pkg, erld_decode, erld_out_buf.
`timescale 1ns / 1ps

// The decoder takes one run-list byte per cycle while the skid stage is
// free; a result goes into the result register, or into the skid stage
// while another waits. The rate is set by the decode step, which inserts
// the byte into its field, sign-extends the delta and does the 64-bit
// cluster add in the cycle the byte arrives. A result register and a skid
// stage keep the input ready while one result waits; with two results
// waiting the input stalls until the consumer takes one. max_runs may be
// written at any time the block is idle and takes effect for the next byte.
module extent_run_list_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_run_byte,
  input  logic        in_list_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [63:0] out_run_lcn,
  output logic [63:0] out_run_length,
  output logic        out_sparse_run,
  output logic [15:0] out_runs_so_far,
  output logic [1:0]  out_end_reason,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_runs
);

  logic [erld_pkg::RUNS_W-1:0] max_runs_r;
  logic                        step;
  logic                        res_valid;
  erld_pkg::res_t              res;
  erld_pkg::res_t              out_res;
  logic                        space;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign step      = in_valid && space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_runs_r <= erld_pkg::MAX_RUNS_RESET;
    end else if (cfg_valid) begin
      max_runs_r <= cfg_max_runs;
    end
  end

  erld_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .run_byte   (in_run_byte),
    .list_start (in_list_start),
    .max_runs   (max_runs_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  erld_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_data  (out_res),
    .out_ready (out_ready)
  );

  assign out_result_kind = out_res.result_kind;
  assign out_run_lcn     = out_res.run_lcn;
  assign out_run_length  = out_res.run_length;
  assign out_sparse_run  = out_res.sparse_run;
  assign out_runs_so_far = out_res.runs_so_far;
  assign out_end_reason  = out_res.end_reason;
  assign out_last        = out_res.last;

  // The input only stalls when both result slots are full.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // A marker always closes the list and carries no run.
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == erld_pkg::KIND_MARKER)) |->
      (out_last && (out_run_lcn == 64'd0) && (out_run_length == 64'd0)))
    else $error("end marker malformed");

  // An open list reports no end reason.
  a_reason_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_end_reason == erld_pkg::REASON_TERMINATOR))
    else $error("end reason set on a run that does not close the list");

  // A stalled result stays put while the consumer is not ready.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_run_lcn)))
    else $error("waiting result changed");

endmodule

[rtl/core/erld_decode.sv]
// Byte decoder of the run-list stream: header parsing, field collection and
// the cluster accumulation. Depends on erld_pkg for the result type.
`timescale 1ns / 1ps

module erld_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [7:0]                     run_byte,
  input  logic                           list_start,
  input  logic [erld_pkg::RUNS_W-1:0]    max_runs,
  output logic                           res_valid,
  output erld_pkg::res_t                 res
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_DELTA  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Places one byte into byte lane idx of a 64-bit accumulator.
  function automatic logic [63:0] insert_byte(input logic [63:0] acc,
                                              input logic [7:0]  b,
                                              input logic [2:0]  idx);
    logic [63:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (idx == 3'(k)) begin
        r[8*k +: 8] = acc[8*k +: 8] | b;
      end
    end
    return r;
  endfunction

  // Sign-extends a delta of cnt bytes; an eight-byte delta is taken as it is.
  function automatic logic [63:0] sext_delta(input logic [63:0] d,
                                             input logic [3:0]  cnt);
    logic [63:0] r;
    logic        sgn;
    r   = d;
    sgn = 1'b0;
    for (int k = 1; k < 8; k++) begin
      if (cnt == 4'(k)) begin
        sgn = d[8*k-1];
      end
    end
    for (int k = 1; k < 8; k++) begin
      if (sgn && (4'(k) >= cnt)) begin
        r[8*k +: 8] = 8'hFF;
      end
    end
    return r;
  endfunction

  phase_t       phase_r, phase_nxt;
  logic [3:0]   bytes_left_r, bytes_left_nxt;
  logic [3:0]   length_count_r, length_count_nxt;
  logic [3:0]   delta_count_r, delta_count_nxt;
  logic [63:0]  length_acc_r, length_acc_nxt;
  logic [63:0]  delta_acc_r, delta_acc_nxt;
  logic [63:0]  cluster_r, cluster_nxt;
  logic [erld_pkg::RUNS_W-1:0] run_count_r, run_count_nxt;

  // State as seen by this item: a list start clears everything first.
  phase_t       phase_eff;
  logic [3:0]   bytes_left_eff, length_count_eff, delta_count_eff;
  logic [63:0]  length_acc_eff, delta_acc_eff, cluster_eff;
  logic [erld_pkg::RUNS_W-1:0] run_count_eff;

  logic [3:0]   lc, dc, bl_dec;
  logic [63:0]  length_ins, delta_ins, delta_used, cluster_sum;
  logic [erld_pkg::RUNS_W-1:0] run_count_inc;
  logic         finish;
  logic         sparse;
  logic         limit_hit;

  assign phase_eff        = list_start ? PH_HEADER : phase_r;
  assign bytes_left_eff   = list_start ? 4'd0 : bytes_left_r;
  assign length_count_eff = list_start ? 4'd0 : length_count_r;
  assign delta_count_eff  = list_start ? 4'd0 : delta_count_r;
  assign length_acc_eff   = list_start ? 64'd0 : length_acc_r;
  assign delta_acc_eff    = list_start ? 64'd0 : delta_acc_r;
  assign cluster_eff      = list_start ? 64'd0 : cluster_r;
  assign run_count_eff    = list_start ? '0 : run_count_r;

  assign lc     = run_byte[3:0];
  assign dc     = run_byte[7:4];
  assign bl_dec = bytes_left_eff - 4'd1;

  assign length_ins = insert_byte(length_acc_eff, run_byte,
                                  3'(length_count_eff - bytes_left_eff));
  assign delta_ins  = insert_byte(delta_acc_eff, run_byte,
                                  3'(delta_count_eff - bytes_left_eff));

  assign delta_used    = (phase_eff == PH_DELTA) ? delta_ins : delta_acc_eff;
  assign sparse        = (delta_count_eff == 4'd0);
  assign cluster_sum   = cluster_eff + sext_delta(delta_used, delta_count_eff);
  assign run_count_inc = run_count_eff + 1'b1;
  assign limit_hit     = (run_count_inc >= max_runs);

  always_comb begin
    phase_nxt        = phase_eff;
    bytes_left_nxt   = bytes_left_eff;
    length_count_nxt = length_count_eff;
    delta_count_nxt  = delta_count_eff;
    length_acc_nxt   = length_acc_eff;
    delta_acc_nxt    = delta_acc_eff;
    cluster_nxt      = cluster_eff;
    run_count_nxt    = run_count_eff;
    finish           = 1'b0;
    res_valid        = 1'b0;
    res.result_kind  = erld_pkg::KIND_MARKER;
    res.run_lcn      = '0;
    res.run_length   = '0;
    res.sparse_run   = 1'b0;
    res.runs_so_far  = run_count_eff;
    res.end_reason   = erld_pkg::REASON_TERMINATOR;
    res.last         = 1'b1;

    case (phase_eff)
      PH_HEADER: begin
        if (run_byte == 8'd0) begin
          res_valid = 1'b1;
          phase_nxt = PH_DONE;
        end else if (run_count_eff >= max_runs) begin
          res_valid      = 1'b1;
          res.end_reason = erld_pkg::REASON_RUN_LIMIT;
          phase_nxt      = PH_DONE;
        end else if (lc == 4'd0) begin
          res_valid      = 1'b1;
          res.end_reason = erld_pkg::REASON_ZERO_LEN;
          phase_nxt      = PH_DONE;
        end else if ((lc > 4'd8) || (dc > 4'd8)) begin
          res_valid      = 1'b1;
          res.end_reason = erld_pkg::REASON_WIDE_COUNT;
          phase_nxt      = PH_DONE;
        end else begin
          length_count_nxt = lc;
          delta_count_nxt  = dc;
          length_acc_nxt   = '0;
          delta_acc_nxt    = '0;
          bytes_left_nxt   = lc;
          phase_nxt        = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        length_acc_nxt = length_ins;
        bytes_left_nxt = bl_dec;
        if (bl_dec == 4'd0) begin
          if (sparse) begin
            finish = 1'b1;
          end else begin
            bytes_left_nxt = delta_count_eff;
            phase_nxt      = PH_DELTA;
          end
        end
      end
      PH_DELTA: begin
        delta_acc_nxt  = delta_ins;
        bytes_left_nxt = bl_dec;
        if (bl_dec == 4'd0) begin
          finish = 1'b1;
        end
      end
      default: begin
        // List closed: bytes are dropped until the next list start.
      end
    endcase

    if (finish) begin
      res_valid       = 1'b1;
      cluster_nxt     = sparse ? cluster_eff : cluster_sum;
      run_count_nxt   = run_count_inc;
      res.result_kind = erld_pkg::KIND_RUN;
      res.run_lcn     = sparse ? cluster_eff : cluster_sum;
      res.run_length  = length_acc_nxt;
      res.sparse_run  = sparse;
      res.runs_so_far = run_count_inc;
      res.last        = limit_hit;
      res.end_reason  = limit_hit ? erld_pkg::REASON_RUN_LIMIT
                                  : erld_pkg::REASON_TERMINATOR;
      phase_nxt       = limit_hit ? PH_DONE : PH_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      bytes_left_r   <= '0;
      length_count_r <= '0;
      delta_count_r  <= '0;
      length_acc_r   <= '0;
      delta_acc_r    <= '0;
      cluster_r      <= '0;
      run_count_r    <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      length_count_r <= length_count_nxt;
      delta_count_r  <= delta_count_nxt;
      length_acc_r   <= length_acc_nxt;
      delta_acc_r    <= delta_acc_nxt;
      cluster_r      <= cluster_nxt;
      run_count_r    <= run_count_nxt;
    end
  end

endmodule

[rtl/core/erld_out_buf.sv]
// Result register with a skid stage, so that input readiness is registered.
// Depends on erld_pkg for the result type.
`timescale 1ns / 1ps

module erld_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  erld_pkg::res_t push_data,
  output logic           space,
  output logic           out_valid,
  output erld_pkg::res_t out_data,
  input  logic           out_ready
);

  logic           main_valid_r, main_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  erld_pkg::res_t main_r, main_nxt;
  erld_pkg::res_t skid_r, skid_nxt;
  logic           pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        // The waiting item moves up; a new one takes its place.
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_nxt       = push_data;
        skid_valid_nxt = push;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

[bench/erld_result_checker.sv]
// Result checker for the extent run-list decoder: watches the byte, result and
// max_runs channels, predicts every result from the accepted bytes and compares.
// Depends on erld_pkg for the result layout, the reason codes and the reset value.
`timescale 1ns / 1ps

module erld_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_run_byte,
  input  logic        in_list_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [63:0] out_run_lcn,
  input  logic [63:0] out_run_length,
  input  logic        out_sparse_run,
  input  logic [15:0] out_runs_so_far,
  input  logic [1:0]  out_end_reason,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_max_runs,
  output int          mismatches,
  output int          outstanding
);

  typedef enum logic [3:0] {
    AWAIT_HEADER = 4'b0001,
    TAKE_LENGTH  = 4'b0010,
    TAKE_DELTA   = 4'b0100,
    LIST_CLOSED  = 4'b1000
  } list_phase_t;

  list_phase_t                 phase_q;
  logic [3:0]                  left_q;
  logic [3:0]                  len_cnt_q;
  logic [3:0]                  dlt_cnt_q;
  logic [63:0]                 len_acc_q;
  logic [63:0]                 dlt_acc_q;
  logic [63:0]                 cluster_q;
  logic [erld_pkg::RUNS_W-1:0] runs_q;
  logic [erld_pkg::RUNS_W-1:0] max_runs_q;

  erld_pkg::res_t due_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_list();
    phase_q   = AWAIT_HEADER;
    left_q    = '0;
    len_cnt_q = '0;
    dlt_cnt_q = '0;
    len_acc_q = '0;
    dlt_acc_q = '0;
    cluster_q = '0;
    runs_q    = '0;
  endfunction

  function automatic void close_list(input erld_pkg::reason_t why);
    erld_pkg::res_t r;
    r.result_kind = erld_pkg::KIND_MARKER;
    r.run_lcn     = '0;
    r.run_length  = '0;
    r.sparse_run  = 1'b0;
    r.runs_so_far = runs_q;
    r.end_reason  = why;
    r.last        = 1'b1;
    due_results.push_back(r);
    phase_q = LIST_CLOSED;
  endfunction

  function automatic void finish_run();
    erld_pkg::res_t r;
    logic [63:0]    delta;
    int             nbits;
    if (dlt_cnt_q != 0) begin
      delta = dlt_acc_q;
      nbits = dlt_cnt_q * 8;
      // A full eight-byte delta already fills the word and is taken as it is.
      if (dlt_cnt_q < 8 && delta[nbits-1])
        delta = delta | ~((64'd1 << nbits) - 64'd1);
      cluster_q = cluster_q + delta;
    end
    runs_q        = runs_q + 1'b1;
    r.result_kind = erld_pkg::KIND_RUN;
    r.run_lcn     = cluster_q;
    r.run_length  = len_acc_q;
    r.sparse_run  = (dlt_cnt_q == 0);
    r.runs_so_far = runs_q;
    if (runs_q >= max_runs_q) begin
      r.end_reason = erld_pkg::REASON_RUN_LIMIT;
      r.last       = 1'b1;
      phase_q      = LIST_CLOSED;
    end else begin
      r.end_reason = erld_pkg::REASON_TERMINATOR;
      r.last       = 1'b0;
      phase_q      = AWAIT_HEADER;
    end
    due_results.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic start);
    logic [3:0] lc;
    logic [3:0] dc;
    logic [2:0] slot;
    if (start)
      clear_list();
    lc = b[3:0];
    dc = b[7:4];
    case (phase_q)
      AWAIT_HEADER: begin
        if (b == 8'h00)
          close_list(erld_pkg::REASON_TERMINATOR);
        else if (runs_q >= max_runs_q)
          close_list(erld_pkg::REASON_RUN_LIMIT);
        else if (lc == 0)
          close_list(erld_pkg::REASON_ZERO_LEN);
        else if (lc > 8 || dc > 8)
          close_list(erld_pkg::REASON_WIDE_COUNT);
        else begin
          len_cnt_q = lc;
          dlt_cnt_q = dc;
          len_acc_q = '0;
          dlt_acc_q = '0;
          left_q    = lc;
          phase_q   = TAKE_LENGTH;
        end
      end
      TAKE_LENGTH: begin
        slot      = 3'(len_cnt_q - left_q);
        len_acc_q = len_acc_q | ({56'd0, b} << (slot * 8));
        left_q    = left_q - 1'b1;
        if (left_q == 0) begin
          if (dlt_cnt_q == 0)
            finish_run();
          else begin
            left_q  = dlt_cnt_q;
            phase_q = TAKE_DELTA;
          end
        end
      end
      TAKE_DELTA: begin
        slot      = 3'(dlt_cnt_q - left_q);
        dlt_acc_q = dlt_acc_q | ({56'd0, b} << (slot * 8));
        left_q    = left_q - 1'b1;
        if (left_q == 0)
          finish_run();
      end
      default: ;
    endcase
  endfunction

  task automatic check_result();
    erld_pkg::res_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing expected", {48'd0, out_runs_so_far}, 64'd0);
    end else begin
      want = due_results.pop_front();
      if (out_result_kind !== want.result_kind)
        report_mismatch("result_kind", {63'd0, out_result_kind}, {63'd0, want.result_kind});
      if (out_run_lcn !== want.run_lcn)
        report_mismatch("run_lcn", out_run_lcn, want.run_lcn);
      if (out_run_length !== want.run_length)
        report_mismatch("run_length", out_run_length, want.run_length);
      if (out_sparse_run !== want.sparse_run)
        report_mismatch("sparse_run", {63'd0, out_sparse_run}, {63'd0, want.sparse_run});
      if (out_runs_so_far !== want.runs_so_far)
        report_mismatch("runs_so_far", {48'd0, out_runs_so_far}, {48'd0, want.runs_so_far});
      if (out_end_reason !== want.end_reason)
        report_mismatch("end_reason", {62'd0, out_end_reason}, {62'd0, want.end_reason});
      if (out_last !== want.last)
        report_mismatch("last", {63'd0, out_last}, {63'd0, want.last});
    end
  endtask

  // Results go first: a result taken at this edge always belongs to an
  // earlier item, and a new register value only applies to later bytes.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_list();
      max_runs_q = erld_pkg::MAX_RUNS_RESET;
      due_results.delete();
    end else begin
      if (out_valid && out_ready)
        check_result();
      if (in_valid && in_ready)
        decode_byte(in_run_byte, in_list_start);
      if (cfg_valid && cfg_ready)
        max_runs_q = cfg_max_runs;
    end
    outstanding = due_results.size();
  end

endmodule

[bench/tb.sv]
// Top of the extent run-list decoder testbench: clock, reset, byte stimulus,
// max_runs writes, result back-pressure and the verdict.
// Depends on erld_pkg, extent_run_list_decoder and erld_result_checker.
`timescale 1ns / 1ps

module tb;

  localparam int    PHASES       = 20;
  localparam int    PHASE_ITEMS  = 100;
  // Roughly five times the slowest plausible run.
  localparam longint LIMIT_CYCLES = 400_000;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  in_run_byte   = 8'h00;
  logic        in_list_start = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        out_result_kind;
  logic [63:0] out_run_lcn;
  logic [63:0] out_run_length;
  logic        out_sparse_run;
  logic [15:0] out_runs_so_far;
  logic [1:0]  out_end_reason;
  logic        out_last;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_runs  = erld_pkg::MAX_RUNS_RESET;

  int          mismatches;
  int          outstanding;
  int          items_sent = 0;
  int          burst_left = 0;
  int          gap_len;
  rx_mode_t    rx_mode    = RX_STEADY;
  int          rx_left    = 0;

  always #6 clk = ~clk;

  extent_run_list_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_run_byte     (in_run_byte),
    .in_list_start   (in_list_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_run_lcn     (out_run_lcn),
    .out_run_length  (out_run_length),
    .out_sparse_run  (out_sparse_run),
    .out_runs_so_far (out_runs_so_far),
    .out_end_reason  (out_end_reason),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_runs    (cfg_max_runs)
  );

  erld_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_run_byte     (in_run_byte),
    .in_list_start   (in_list_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_run_lcn     (out_run_lcn),
    .out_run_length  (out_run_length),
    .out_sparse_run  (out_sparse_run),
    .out_runs_so_far (out_runs_so_far),
    .out_end_reason  (out_end_reason),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_runs    (cfg_max_runs),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // The result side switches between steady acceptance, coin-flip and
  // mostly-stalled patterns, with the odd hard stall in between.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 25) : $urandom_range(10, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_STEADY: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= 1'b0;
    endcase
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one item; bursts of random length are separated by random gaps.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
      gap_len    = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                : $urandom_range(0, 3);
      if (gap_len != 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_run_byte   <= b;
    in_list_start <= start;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Holds the byte stream back until every expected result has come, then
  // allows for a byte that closes nothing but may still be in flight.
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_runs(input logic [15:0] value);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_max_runs <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // One encoded list: mostly well formed with random contents, sometimes cut
  // short or closed by a malformed header, and now and then plain noise.
  task automatic send_list();
    int         n_runs;
    int         ending;
    logic [3:0] lc;
    logic [3:0] dc;
    logic       st;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 12)) send_byte(pick_byte(), ($urandom_range(0, 7) == 0));
    end else begin
      st     = ($urandom_range(0, 9) != 0);
      n_runs = $urandom_range(0, 6);
      repeat (n_runs) begin
        lc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 8))
                                         : 4'($urandom_range(1, 4));
        dc = 4'($urandom_range(0, 8));
        send_byte({dc, lc}, st);
        st = 1'b0;
        repeat (lc) send_byte(pick_byte(), 1'b0);
        repeat (dc) send_byte(pick_byte(), 1'b0);
      end
      ending = $urandom_range(0, 9);
      case (ending)
        6:       send_byte({4'($urandom_range(1, 15)), 4'h0}, st);
        7:       send_byte({4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))}, st);
        8:       send_byte({4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))}, st);
        9:       ;
        default: send_byte(8'h00, st);
      endcase
      repeat ($urandom_range(0, 2)) send_byte(pick_byte(), 1'b0);
    end
  endtask

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          phase_base;
    logic [15:0] limit_val;

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    write_max_runs(16'hFFFF);

    // Bytes before any list start are decoded as a list already open.
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    // One length byte and a negative one-byte delta, wrapping the cluster.
    send_byte(8'h11, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    // An eight-byte delta is added without sign extension.
    send_byte(8'h81, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h01, 1'b0);
    repeat (6) send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    // Ignored after the terminator.
    send_byte(8'hA5, 1'b0);
    // Wide length count, zero length count ahead of a wide delta, wide delta.
    send_byte(8'h0F, 1'b1);
    send_byte(8'h90, 1'b1);
    send_byte(8'h91, 1'b1);

    wait_drained();
    write_max_runs(16'd1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h11, 1'b0);

    // Each phase writes a new limit; a list left open across the write sees a
    // limit that may now sit at or below its run count.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       limit_val = 16'd1;
        1:       limit_val = 16'hFFFF;
        2:       limit_val = 16'd2;
        default: limit_val = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                          : 16'($urandom_range(1, 6));
      endcase
      write_max_runs(limit_val);
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) send_list();
    end

    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[extent_run_list_decoder.f]
rtl/core/erld_pkg.sv
rtl/core/erld_decode.sv
rtl/core/erld_out_buf.sv
rtl/core/extent_run_list_decoder.sv
bench/erld_result_checker.sv
bench/tb.sv
